FILE: hdl/lts_pkg.sv
// Package for the lexical token scanner: token kinds, scan modes, character
// classes and keyword table. No dependencies.
package lts_pkg;

  localparam int unsigned PosBits  = 32;
  localparam int unsigned LenBits  = 16;
  localparam int unsigned LineBits = 20;
  localparam int unsigned ColBits  = 16;
  localparam int unsigned KwMaxLen = 9;
  localparam int unsigned KwIdxBits = $clog2(KwMaxLen);
  localparam int unsigned KwLenBits = $clog2(KwMaxLen + 1);

  localparam logic [5:0] K_END = 6'd0, K_NUM = 6'd1, K_FLOAT = 6'd2, K_STRING = 6'd3,
    K_ID = 6'd4, K_KW0 = 6'd5;
  localparam logic [5:0] K_PLUS = 6'd31, K_MINUS = 6'd32, K_DIV = 6'd33, K_LPAREN = 6'd34,
    K_RPAREN = 6'd35, K_LBRACKET = 6'd36, K_RBRACKET = 6'd37, K_LBRACE = 6'd38,
    K_RBRACE = 6'd39, K_SEMI = 6'd40, K_COLON = 6'd41, K_COMMA = 6'd42, K_DOT = 6'd43,
    K_POW = 6'd44, K_MUL = 6'd45, K_EQ = 6'd46, K_ASSIGN = 6'd47, K_LEQ = 6'd48,
    K_LT = 6'd49, K_GEQ = 6'd50, K_GT = 6'd51, K_NE = 6'd52, K_NOT = 6'd53,
    K_AND = 6'd54, K_AMP = 6'd55, K_OR = 6'd56, K_ERR = 6'd57;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_FRAC, M_STR, M_STR_ESC, M_OP, M_LINE_CMT, M_BLOCK,
    M_BLOCK_STAR
  } mode_e;

  typedef struct packed {
    logic [5:0]          kind;
    logic [PosBits-1:0]  offset;
    logic [LenBits-1:0]  length;
    logic [LineBits-1:0] line;
    logic [ColBits-1:0]  column;
    logic [7:0]          err;
    logic                last;
  } token_t;

  typedef logic [KwMaxLen*8-1:0] kw_word_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h0a || c == 8'h0d || c == 8'h09;
  endfunction

  function automatic logic [5:0] single_op_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "+": k = K_PLUS;     "-": k = K_MINUS;    "/": k = K_DIV;
      "(": k = K_LPAREN;   ")": k = K_RPAREN;   "[": k = K_LBRACKET;
      "]": k = K_RBRACKET; "{": k = K_LBRACE;   "}": k = K_RBRACE;
      ";": k = K_SEMI;     ":": k = K_COLON;    ",": k = K_COMMA;
      ".": k = K_DOT;      "*": k = K_MUL;      "=": k = K_ASSIGN;
      "<": k = K_LT;       ">": k = K_GT;       "!": k = K_NOT;
      "&": k = K_AMP;
      default: k = K_ERR;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] pair_char(input logic [7:0] p);
    logic [7:0] r;
    case (p)
      "*": r = "*";
      "&": r = "&";
      "|": r = "|";
      "=", "<", ">", "!": r = "=";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] p);
    logic [5:0] k;
    case (p)
      "*": k = K_POW;
      "=": k = K_EQ;
      "<": k = K_LEQ;
      ">": k = K_GEQ;
      "!": k = K_NE;
      "&": k = K_AND;
      default: k = K_OR;
    endcase
    return k;
  endfunction

  // keyword text, first character in the low byte, zero filled
  function automatic kw_word_t kw_text(input int unsigned k);
    logic [8*KwMaxLen-1:0] s;
    kw_word_t w;
    int unsigned i;
    case (k)
      0: s = "sqrt";       1: s = "print";     2: s = "if";
      3: s = "then";       4: s = "else";      5: s = "endif";
      6: s = "while";      7: s = "do";        8: s = "enddo";
      9: s = "dowhile";    10: s = "endwhile"; 11: s = "break";
      12: s = "switch";    13: s = "case";     14: s = "default";
      15: s = "endswitch"; 16: s = "var";      17: s = "struct";
      18: s = "true";      19: s = "false";    20: s = "fun";
      21: s = "endfun";    22: s = "new";      23: s = "return";
      24: s = "template";
      default: s = "auto";
    endcase
    w = '0;
    // string literal is right aligned, last char lowest: reverse into w
    for (i = 0; i < KwMaxLen; i++) begin
      w[i*8 +: 8] = s[(KwMaxLen-1-i)*8 +: 8];
    end
    // shift down by leading zero bytes
    for (i = 0; i < KwMaxLen; i++) begin
      if (w[7:0] == 8'h00) begin
        w = w >> 8;
      end
    end
    return w;
  endfunction

  function automatic logic [KwLenBits-1:0] kw_len(input int unsigned k);
    kw_word_t w;
    logic [KwLenBits-1:0] n;
    int unsigned i;
    w = kw_text(k);
    n = '0;
    for (i = 0; i < KwMaxLen; i++) begin
      if (w[i*8 +: 8] != 8'h00) begin
        n = KwLenBits'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

FILE: hdl/lexical_token_scanner_top.sv
// Lexical token scanner top level: byte stream in, token stream out.
// Depends on lts_pkg.
// The first token beat of an accepted byte is registered and valid in the next cycle.
// Throughput: one byte per cycle while m_axis_tready is high; a byte that yields
// two tokens holds s_axis_tready low while the second beat drains.
// Reset: asynchronous, active low; mode idle, line and column one, position zero.
module lexical_token_scanner_top
  import lts_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] char_byte
  input  logic         s_axis_tuser,   // end_of_input
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // token_kind, start_offset, token_length,
                                       // token_line, token_column, error_byte, zero pad
  output logic         m_axis_tlast    // last_of_run
);

  mode_e               mode_q, mode_d;
  logic [7:0]          op_q, op_d;
  logic [PosBits-1:0]  pos_q, pos_d;
  logic [LineBits-1:0] line_q, line_d, tline_q, tline_d;
  logic [ColBits-1:0]  col_q, col_d, tcol_q, tcol_d;
  logic [PosBits-1:0]  toff_q, toff_d;
  logic [LenBits-1:0]  len_q, len_d;
  logic [7:0]          kw_q [KwMaxLen];
  logic                kw_we;
  logic [KwIdxBits-1:0] kw_wa;
  logic [7:0]          kw_wd;

  token_t              out0_q, out1_q, t0, t1;
  logic                v0_q, v1_q;
  logic [1:0]          n_tok;
  logic                accept, free;

  logic [7:0]          c;
  logic                eoi;
  logic [5:0]          id_kind;
  logic [LenBits-1:0]  len_inc;

  assign c   = s_axis_tdata;
  assign eoi = s_axis_tuser;

  // output holds up to two beats; the next byte enters once the holding beat leaves
  assign free          = !v1_q && (!v0_q || m_axis_tready);
  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;

  assign len_inc = (len_q == '1) ? len_q : len_q + 1'b1;

  always_comb begin
    id_kind = K_ID;
    for (int k = 0; k < 26; k++) begin
      logic hit;
      kw_word_t w;
      logic [KwLenBits-1:0] n;
      w = kw_text(k);
      n = kw_len(k);
      hit = (len_q == LenBits'(n));
      for (int i = 0; i < KwMaxLen; i++) begin
        if (i < int'(n) && kw_q[i] != w[i*8 +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        id_kind = K_KW0 + 6'(k);
      end
    end
  end

  function automatic token_t pend(input logic [5:0] k, input logic [LenBits-1:0] l,
                                  input logic [7:0] e, input logic [PosBits-1:0] o,
                                  input logic [LineBits-1:0] ln, input logic [ColBits-1:0] cl);
    token_t t;
    t.kind = k; t.offset = o; t.length = l; t.line = ln; t.column = cl;
    t.err = e; t.last = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic taken;
    logic [5:0] sk;
    mode_d = mode_q; op_d = op_q; pos_d = pos_q; line_d = line_q; col_d = col_q;
    toff_d = toff_q; tline_d = tline_q; tcol_d = tcol_q; len_d = len_q;
    kw_we = 1'b0; kw_wa = '0; kw_wd = c;
    t0 = '0; t1 = '0; n_tok = 2'd0; taken = 1'b1;
    sk = single_op_kind(op_q);
    if (eoi) begin
      n_tok = 2'd1;
      case (mode_q)
        M_IDENT: begin t0 = pend(id_kind, len_q, 8'h00, toff_q, tline_q, tcol_q); n_tok = 2'd2; end
        M_INT: begin t0 = pend(K_NUM, len_q, 8'h00, toff_q, tline_q, tcol_q); n_tok = 2'd2; end
        M_FRAC: begin t0 = pend(K_FLOAT, len_q, 8'h00, toff_q, tline_q, tcol_q); n_tok = 2'd2; end
        M_STR, M_STR_ESC: begin
          t0 = pend(K_STRING, len_q, 8'h00, toff_q, tline_q, tcol_q); n_tok = 2'd2;
        end
        M_OP: begin
          t0 = pend(sk, LenBits'(1), (sk == K_ERR) ? op_q : 8'h00, toff_q, tline_q, tcol_q);
          n_tok = 2'd2;
        end
        default: ;
      endcase
      if (n_tok == 2'd2) begin
        t1 = pend(K_END, '0, 8'h00, pos_q, line_q, col_q);
        t1.last = 1'b1;
      end else begin
        t0 = pend(K_END, '0, 8'h00, pos_q, line_q, col_q);
        t0.last = 1'b1;
      end
      mode_d = M_IDLE;
    end else begin
      case (mode_q)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            if (len_q < LenBits'(KwMaxLen)) begin
              kw_we = 1'b1; kw_wa = KwIdxBits'(len_q);
            end
            len_d = len_inc;
          end else begin
            t0 = pend(id_kind, len_q, 8'h00, toff_q, tline_q, tcol_q); n_tok = 2'd1;
            taken = 1'b0;
          end
        end
        M_INT: begin
          if (is_digit(c)) len_d = len_inc;
          else if (c == ".") begin len_d = len_inc; mode_d = M_FRAC; end
          else begin
            t0 = pend(K_NUM, len_q, 8'h00, toff_q, tline_q, tcol_q); n_tok = 2'd1;
            taken = 1'b0;
          end
        end
        M_FRAC: begin
          if (is_digit(c)) len_d = len_inc;
          else begin
            t0 = pend(K_FLOAT, len_q, 8'h00, toff_q, tline_q, tcol_q); n_tok = 2'd1;
            taken = 1'b0;
          end
        end
        M_STR: begin
          len_d = len_inc;
          if (c == "\\") mode_d = M_STR_ESC;
          else if (c == "\"") begin
            t0 = pend(K_STRING, len_inc, 8'h00, toff_q, tline_q, tcol_q); n_tok = 2'd1;
            mode_d = M_IDLE;
          end
        end
        M_STR_ESC: begin len_d = len_inc; mode_d = M_STR; end
        M_OP: begin
          if (op_q == "/" && c == "/") mode_d = M_LINE_CMT;
          else if (op_q == "/" && c == "*") mode_d = M_BLOCK;
          else if (pair_char(op_q) != 8'h00 && c == pair_char(op_q)) begin
            t0 = pend(pair_kind(op_q), LenBits'(2), 8'h00, toff_q, tline_q, tcol_q);
            n_tok = 2'd1; mode_d = M_IDLE;
          end else begin
            t0 = pend(sk, LenBits'(1), (sk == K_ERR) ? op_q : 8'h00, toff_q, tline_q, tcol_q);
            n_tok = 2'd1; taken = 1'b0;
          end
        end
        M_LINE_CMT: if (c == 8'h0a) mode_d = M_IDLE;
        M_BLOCK: if (c == "*") mode_d = M_BLOCK_STAR;
        M_BLOCK_STAR: begin
          if (c == "/") mode_d = M_IDLE;
          else if (c != "*") mode_d = M_BLOCK;
        end
        default: taken = 1'b0;
      endcase
      if (!taken) begin
        mode_d = M_IDLE;
        if (!is_space(c)) begin
          toff_d = pos_q; tline_d = line_q; tcol_d = col_q; len_d = LenBits'(1);
          if (is_digit(c)) mode_d = M_INT;
          else if (is_alpha(c) || c == "_") begin
            mode_d = M_IDENT; kw_we = 1'b1; kw_wa = '0;
          end else if (c == "\"") mode_d = M_STR;
          else if (c == "/" || pair_char(c) != 8'h00) begin
            op_d = c; mode_d = M_OP;
          end else begin
            if (n_tok == 2'd0) begin
              t0 = pend(single_op_kind(c), LenBits'(1),
                        (single_op_kind(c) == K_ERR) ? c : 8'h00, pos_q, line_q, col_q);
            end else begin
              t1 = pend(single_op_kind(c), LenBits'(1),
                        (single_op_kind(c) == K_ERR) ? c : 8'h00, pos_q, line_q, col_q);
            end
            n_tok = n_tok + 2'd1;
          end
        end
      end
      pos_d = pos_q + 1'b1;
      if (c == 8'h0a) begin
        if (line_q != '1) line_d = line_q + 1'b1;
        col_d = ColBits'(1);
      end else if (col_q != '1) begin
        col_d = col_q + 1'b1;
      end
      if (n_tok == 2'd1) t0.last = 1'b1;
      if (n_tok == 2'd2) t1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; op_q <= '0; pos_q <= '0; line_q <= LineBits'(1);
      col_q <= ColBits'(1); toff_q <= '0; tline_q <= LineBits'(1);
      tcol_q <= ColBits'(1); len_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d; op_q <= op_d; pos_q <= pos_d; line_q <= line_d;
      col_q <= col_d; toff_q <= toff_d; tline_q <= tline_d; tcol_q <= tcol_d;
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && kw_we) kw_q[kw_wa] <= kw_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0; v1_q <= 1'b0;
    end else if (accept) begin
      v0_q <= (n_tok != 2'd0); v1_q <= (n_tok == 2'd2);
    end else if (v0_q && m_axis_tready) begin
      v0_q <= v1_q; v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out0_q <= t0; out1_q <= t1;
    end else if (v0_q && m_axis_tready) begin
      out0_q <= out1_q;
    end
  end

  assign m_axis_tvalid = v0_q;
  assign m_axis_tlast  = out0_q.last;
  assign m_axis_tdata  = {6'b000000, out0_q.err, out0_q.column, out0_q.line, out0_q.length,
                          out0_q.offset, out0_q.kind};

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> v0_q) else $error("second beat without first");
  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> !s_axis_tready) else $error("byte taken with two beats held");
  a_pair_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && m_axis_tready) |=> (v0_q && !v1_q)) else $error("pair drain wrong");
  a_line_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0) else $error("line is zero");

endmodule

FILE: tb/tb_lexical_token_scanner_top.sv
// Self-checking testbench for lexical_token_scanner_top: drives source bytes and
// end markers, comparing each token beat with a local scanner model or a typed row.
// Depends on lts_pkg and the scanner RTL.
module tb_lexical_token_scanner_top
  import lts_pkg::*;
();

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] offset;
    logic [15:0] length;
    logic [19:0] line;
    logic [15:0] column;
    logic [7:0]  err;
    logic        last;
  } tok_s;

  typedef struct {
    string txt;
    bit    use_b;
    byte   b;
    bit    eoi;
    bit    typed;
    tok_s  exp;
  } row_s;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tlast;

  lexical_token_scanner_top dut (.*);

  always #5 clk_i = ~clk_i;

  tok_s        token_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          sent = 0;
  bit          calm = 1'b0;
  bit          injected = 1'b0;
  tok_s        injected_tok;

  // scanner state
  mode_e       mode;
  logic [7:0]  op_pend;
  logic [31:0] pos;
  logic [19:0] cur_line;
  logic [15:0] cur_col;
  logic [31:0] st_off;
  logic [19:0] st_line;
  logic [15:0] st_col;
  logic [15:0] lex_len;
  logic [7:0]  kw_buf[9];
  tok_s        step_toks[$];

  string keywords[26] = '{"sqrt", "print", "if", "then", "else", "endif", "while", "do",
    "enddo", "dowhile", "endwhile", "break", "switch", "case", "default", "endswitch",
    "var", "struct", "true", "false", "fun", "endfun", "new", "return", "template",
    "auto"};

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [5:0] op_kind(logic [7:0] c);
    case (c)
      "+": return K_PLUS;     "-": return K_MINUS;    "/": return K_DIV;
      "(": return K_LPAREN;   ")": return K_RPAREN;   "[": return K_LBRACKET;
      "]": return K_RBRACKET; "{": return K_LBRACE;   "}": return K_RBRACE;
      ";": return K_SEMI;     ":": return K_COLON;    ",": return K_COMMA;
      ".": return K_DOT;      "*": return K_MUL;      "=": return K_ASSIGN;
      "<": return K_LT;       ">": return K_GT;       "!": return K_NOT;
      "&": return K_AMP;
      default: return K_ERR;
    endcase
  endfunction

  function automatic logic [7:0] second_of(logic [7:0] p);
    case (p)
      "*", "&", "|": return p;
      "=", "<", ">", "!": return "=";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [5:0] double_kind(logic [7:0] p);
    case (p)
      "*": return K_POW;
      "=": return K_EQ;
      "<": return K_LEQ;
      ">": return K_GEQ;
      "!": return K_NE;
      "&": return K_AND;
      default: return K_OR;
    endcase
  endfunction

  function automatic logic [5:0] word_kind();
    bit same;
    for (int k = 0; k < 26; k++) begin
      if (keywords[k].len() == lex_len) begin
        same = 1'b1;
        for (int i = 0; i < keywords[k].len(); i++) begin
          if (kw_buf[i] != keywords[k][i]) same = 1'b0;
        end
        if (same) return K_KW0 + 6'(k);
      end
    end
    return K_ID;
  endfunction

  task automatic push_tok(logic [5:0] k, logic [31:0] o, logic [15:0] l, logic [19:0] ln,
                          logic [15:0] col, logic [7:0] e);
    step_toks.push_back('{k, o, l, ln, col, e, 1'b0});
  endtask

  task automatic push_pending(logic [5:0] k, logic [15:0] l, logic [7:0] e);
    push_tok(k, st_off, l, st_line, st_col, e);
  endtask

  task automatic flush_op();
    logic [5:0] k;
    k = op_kind(op_pend);
    push_pending(k, 16'd1, k == K_ERR ? op_pend : 8'h00);
  endtask

  task automatic open_token(logic [7:0] c);
    logic [5:0] k;
    if (c == " " || c == 8'h0a || c == 8'h0d || c == 8'h09) return;
    st_off = pos;
    st_line = cur_line;
    st_col = cur_col;
    lex_len = 16'd1;
    if (digit(c)) begin
      mode = M_INT;
    end else if (letter(c) || c == "_") begin
      kw_buf[0] = c;
      mode = M_IDENT;
    end else if (c == 8'h22) begin
      mode = M_STR;
    end else if (c == "/" || second_of(c) != 8'h00) begin
      op_pend = c;
      mode = M_OP;
    end else begin
      k = op_kind(c);
      push_pending(k, 16'd1, k == K_ERR ? c : 8'h00);
    end
  endtask

  task automatic grow();
    if (lex_len != 16'hffff) lex_len++;
  endtask

  task automatic scan_byte(logic [7:0] c, logic eoi);
    bit taken;
    taken = 1'b1;
    step_toks.delete();
    if (eoi) begin
      case (mode)
        M_IDENT: push_pending(word_kind(), lex_len, 8'h00);
        M_INT: push_pending(K_NUM, lex_len, 8'h00);
        M_FRAC: push_pending(K_FLOAT, lex_len, 8'h00);
        M_STR, M_STR_ESC: push_pending(K_STRING, lex_len, 8'h00);
        M_OP: flush_op();
        default: ;
      endcase
      push_tok(K_END, pos, 16'd0, cur_line, cur_col, 8'h00);
      mode = M_IDLE;
    end else begin
      case (mode)
        M_IDENT: begin
          if (letter(c) || digit(c) || c == "_") begin
            if (lex_len < 9) kw_buf[lex_len] = c;
            grow();
          end else begin
            push_pending(word_kind(), lex_len, 8'h00);
            mode = M_IDLE;
            taken = 1'b0;
          end
        end
        M_INT: begin
          if (digit(c)) begin
            grow();
          end else if (c == ".") begin
            grow();
            mode = M_FRAC;
          end else begin
            push_pending(K_NUM, lex_len, 8'h00);
            mode = M_IDLE;
            taken = 1'b0;
          end
        end
        M_FRAC: begin
          if (digit(c)) begin
            grow();
          end else begin
            push_pending(K_FLOAT, lex_len, 8'h00);
            mode = M_IDLE;
            taken = 1'b0;
          end
        end
        M_STR: begin
          grow();
          if (c == 8'h5c) begin
            mode = M_STR_ESC;
          end else if (c == 8'h22) begin
            push_pending(K_STRING, lex_len, 8'h00);
            mode = M_IDLE;
          end
        end
        M_STR_ESC: begin
          grow();
          mode = M_STR;
        end
        M_OP: begin
          if (op_pend == "/" && c == "/") begin
            mode = M_LINE_CMT;
          end else if (op_pend == "/" && c == "*") begin
            mode = M_BLOCK;
          end else if (second_of(op_pend) != 8'h00 && c == second_of(op_pend)) begin
            push_pending(double_kind(op_pend), 16'd2, 8'h00);
            mode = M_IDLE;
          end else begin
            flush_op();
            mode = M_IDLE;
            taken = 1'b0;
          end
        end
        M_LINE_CMT: if (c == 8'h0a) mode = M_IDLE;
        M_BLOCK: if (c == "*") mode = M_BLOCK_STAR;
        M_BLOCK_STAR: begin
          if (c == "/") mode = M_IDLE;
          else if (c != "*") mode = M_BLOCK;
        end
        default: begin
          mode = M_IDLE;
          taken = 1'b0;
        end
      endcase
      if (!taken) open_token(c);
      pos++;
      if (c == 8'h0a) begin
        if (cur_line != 20'hfffff) cur_line++;
        cur_col = 16'd1;
      end else if (cur_col != 16'hffff) begin
        cur_col++;
      end
    end
    if (step_toks.size() > 0) step_toks[$].last = 1'b1;
    if (injected) begin
      if (step_toks.size() != 1) begin
        $display("directed row predicts %0d tokens", step_toks.size());
        mismatches++;
      end
      token_q.push_back(injected_tok);
    end else begin
      foreach (step_toks[i]) token_q.push_back(step_toks[i]);
    end
  endtask

  task automatic send(logic [7:0] c, logic eoi);
    bit done;
    bit shown;
    done = 1'b0;
    shown = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      if (!shown && !calm && $urandom_range(99) < 27) begin
        s_axis_tvalid = 1'b0;
      end else begin
        if (!shown) begin
          s_axis_tdata = eoi ? 8'($urandom) : c;
          s_axis_tuser = eoi;
        end
        s_axis_tvalid = 1'b1;
        shown = 1'b1;
      end
      @(posedge clk_i);
      if (s_axis_tvalid && s_axis_tready) begin
        scan_byte(eoi ? 8'h00 : s_axis_tdata, eoi);
        sent++;
        done = 1'b1;
      end
    end
    injected = 1'b0;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send(s[i], 1'b0);
  endtask

  task automatic random_token();
    string s;
    int n;
    case ($urandom_range(13))
      0, 1: send_text(keywords[$urandom_range(25)]);
      2, 3: begin
        n = $urandom_range(12, 1);
        s = "";
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(3))
            0: s = {s, string'(8'($urandom_range("z", "a")))};
            1: s = {s, string'(8'($urandom_range("Z", "A")))};
            2: s = {s, "_"};
            default: s = {s, string'(8'($urandom_range("9", "0")))};
          endcase
        end
        if (!digit(s[0])) send_text(s);
      end
      4: begin
        n = $urandom_range(5, 1);
        for (int i = 0; i < n; i++) send(8'($urandom_range("9", "0")), 1'b0);
        if ($urandom_range(1)) begin
          send(".", 1'b0);
          n = $urandom_range(4);
          for (int i = 0; i < n; i++) send(8'($urandom_range("9", "0")), 1'b0);
        end
      end
      5: begin
        send(8'h22, 1'b0);
        n = $urandom_range(8);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(4) == 0) send(8'h5c, 1'b0);
          send(8'($urandom_range(126, 32)), 1'b0);
        end
        if ($urandom_range(7) != 0) send(8'h22, 1'b0);
      end
      6, 7: begin
        s = "+-/()[]{};:=<>!&|,.*";
        send(s[$urandom_range(s.len() - 1)], 1'b0);
        if ($urandom_range(1)) send(s[$urandom_range(s.len() - 1)], 1'b0);
      end
      8: send_text($urandom_range(1) ? "// note x\n" : "/* a * b **/");
      9, 10: begin
        s = " \n\r\t";
        send(s[$urandom_range(3)], 1'b0);
      end
      11: send(8'($urandom), 1'b0);
      12: send(8'($urandom_range(255, 128)), 1'b0);
      default: send(8'h00, 1'b1);
    endcase
  endtask

  row_s rows[] = '{
    '{"", 0, 0, 1, 1, '{K_END, 32'd0, 16'd0, 20'd1, 16'd1, 8'h00, 1'b1}},
    '{"", 1, 8'h00, 0, 1, '{K_ERR, 32'd0, 16'd1, 20'd1, 16'd1, 8'h00, 1'b1}},
    '{"", 1, 8'hff, 0, 1, '{K_ERR, 32'd1, 16'd1, 20'd1, 16'd2, 8'hff, 1'b1}},
    '{"", 1, 8'h5b, 0, 1, '{K_LBRACKET, 32'd2, 16'd1, 20'd1, 16'd3, 8'h00, 1'b1}},
    '{"", 1, 8'h80, 0, 1, '{K_ERR, 32'd3, 16'd1, 20'd1, 16'd4, 8'h80, 1'b1}},
    '{"| x|y ", 0, 0, 0, 0, '0},
    '{"sqrt print if then else endif while do enddo dowhile endwhile break ", 0, 0, 0, 0, '0},
    '{"switch case default endswitch var struct true false fun endfun new ", 0, 0, 0, 0, '0},
    '{"return template auto abcdefghijk endswitchx _a9 Z\n", 0, 0, 0, 0, '0},
    '{"12 3.45 6. 7.a \"a\\\"b\" \"\\\\\" ", 0, 0, 0, 0, '0},
    '{"// line\n/* * */ /*/ x */ ", 0, 0, 0, 0, '0},
    '{"** == <= >= != && || & ! < > = * / + - ( ) ] { } ; : , . @~", 0, 0, 0, 0, '0},
    '{"abc", 0, 0, 1, 0, '0},
    '{"\"open", 0, 0, 1, 0, '0},
    '{"/* open", 0, 0, 1, 0, '0},
    '{"<", 0, 0, 1, 0, '0},
    '{"\r\t\n42", 0, 0, 1, 0, '0}
  };

  always @(posedge clk_i) begin
    tok_s got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[5:0], m_axis_tdata[37:6], m_axis_tdata[53:38],
              m_axis_tdata[73:54], m_axis_tdata[89:74], m_axis_tdata[97:90], m_axis_tlast};
      if (token_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token beat %p", got);
      end else begin
        want = token_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("token mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= calm || $urandom_range(99) >= 27;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == 2_000_000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int waited;
    mode = M_IDLE;
    op_pend = '0;
    pos = '0;
    cur_line = 20'd1;
    cur_col = 16'd1;
    st_off = '0;
    st_line = 20'd1;
    st_col = 16'd1;
    lex_len = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[r]) begin
      if (rows[r].use_b) begin
        injected = rows[r].typed;
        injected_tok = rows[r].exp;
        send(rows[r].b, 1'b0);
      end else begin
        send_text(rows[r].txt);
        if (rows[r].eoi) begin
          injected = rows[r].typed;
          injected_tok = rows[r].exp;
          send(8'h00, 1'b1);
        end
      end
    end

    while (sent < 1800) begin
      calm = sent >= 700 && sent < 1000;
      random_token();
    end
    calm = 1'b0;
    send(8'h00, 1'b1);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    waited = 0;
    while (token_q.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
